### hw/rtl/rational_add_mul_reduce_defines.svh
// Assertion macros used by rational_add_mul_reduce.
`ifndef RATIONAL_ADD_MUL_REDUCE_DEFINES_SVH
`define RATIONAL_ADD_MUL_REDUCE_DEFINES_SVH
`ifndef SYNTHESIS
`define RAMR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RAMR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define RAMR_ASSERT(lbl, clk, rst_n, prop)
`define RAMR_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

### hw/rtl/ramr_pkg.sv
package ramr_pkg;
  // Datapath width: cross products and their sum stay below 2^33 in magnitude.
  localparam int unsigned DW = 35;
  localparam int unsigned CW = $clog2(DW);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_GWAIT,
    ST_RNUM,
    ST_RDEN,
    ST_STORE,
    ST_MSN0,
    ST_MSN1,
    ST_MSD,
    ST_MPN,
    ST_MPD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SUM,
    PH_PROD
  } phase_e;
endpackage

### hw/rtl/ramr_div.sv
module ramr_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [ramr_pkg::DW-1:0]    dividend_i,
  input  logic signed [ramr_pkg::DW-1:0]    divisor_i,
  output logic signed [ramr_pkg::DW-1:0]    quot_o,
  output logic signed [ramr_pkg::DW-1:0]    rem_o,
  output ramr_pkg::div_stat_t               stat_o
);
  import ramr_pkg::*;

  logic [DW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic          qneg_q, qneg_d, rneg_q, rneg_d;
  logic [DW-1:0] shifted;
  logic [DW:0]   trial;

  assign shifted = {rem_q[DW-2:0], quo_q[DW-1]};
  assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[DW-1] ? -dividend_i : dividend_i;
      dvs_d  = divisor_i[DW-1] ? -divisor_i : divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      qneg_d = dividend_i[DW-1] ^ divisor_i[DW-1];
      rneg_d = dividend_i[DW-1];
    end else if (busy_q) begin
      // one restoring step per cycle
      if (!trial[DW]) begin
        rem_d = trial[DW-1:0];
      end else begin
        rem_d = shifted;
      end
      quo_d = {quo_q[DW-2:0], ~trial[DW]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign quot_o      = qneg_q ? -quo_q : quo_q;
  assign rem_o       = rneg_q ? -rem_q : rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

### hw/rtl/rational_add_mul_reduce.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o  first_num, first_den, second_num, second_den
// out      output     out_valid_o/out_stall_i reduced, sum, prod fractions and flags
// One transaction at a time; the input stalls while it is in work.
// Each Euclid step and each reduce division runs on the one shared restoring
// divider (one quotient bit a cycle); cross products take 5 combinational
// multiplies, one per sequencer state.
// Reset is asynchronous, active low, and clears the sequencer and valid.
// A result waits in the output register; a stalled output delays the next finish.
module rational_add_mul_reduce (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] first_num_i,
  input  logic signed [15:0] first_den_i,
  input  logic signed [15:0] second_num_i,
  input  logic signed [15:0] second_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] reduced_num_o,
  output logic signed [15:0] reduced_den_o,
  output logic signed [31:0] sum_num_o,
  output logic signed [30:0] sum_den_o,
  output logic signed [30:0] prod_num_o,
  output logic signed [30:0] prod_den_o,
  output logic               reduce_undefined_o,
  output logic               sum_undefined_o,
  output logic               prod_undefined_o
);
  import ramr_pkg::*;
  `include "rational_add_mul_reduce_defines.svh"

  state_e state_q, state_d;
  phase_e phase_q;

  logic signed [DW-1:0] m_q, n_q, num_q, den_q, t_q;
  logic signed [16:0]   rn_q, rd_q;
  logic signed [15:0]   bn_q, bd_q;
  logic                 undef_q, ua_q, us_q;
  logic signed [31:0]   sn_q;
  logic signed [30:0]   sd_q;
  logic                 out_valid_q;

  logic                 div_start;
  logic signed [DW-1:0] div_a, div_b, div_quot, div_rem;
  div_stat_t            div_stat;

  logic signed [16:0]   mul_a;
  logic signed [15:0]   mul_b;
  logic signed [32:0]   mul_p;
  logic signed [DW-1:0] mul_x;

  logic                 accept;
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  ramr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  assign mul_p = mul_a * mul_b;
  assign mul_x = DW'(mul_p);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_GCD;
      ST_GCD: begin
        if (n_q != '0) state_d = ST_GWAIT;
        else if (m_q == '0) state_d = ST_STORE;
        else state_d = ST_RNUM;
      end
      ST_GWAIT: if (div_stat.done) state_d = ST_GCD;
      ST_RNUM:  if (div_stat.done) state_d = ST_RDEN;
      ST_RDEN:  if (div_stat.done) state_d = ST_STORE;
      ST_STORE: begin
        case (phase_q)
          PH_FIRST: state_d = ST_MSN0;
          PH_SUM:   state_d = ST_MPN;
          default:  state_d = ST_OUT;
        endcase
      end
      ST_MSN0:  state_d = ST_MSN1;
      ST_MSN1:  state_d = ST_MSD;
      ST_MSD:   state_d = ST_GCD;
      ST_MPN:   state_d = ST_MPD;
      ST_MPD:   state_d = ST_GCD;
      ST_OUT:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // shared unit controls
  always_comb begin
    div_start = 1'b0;
    div_a     = m_q;
    div_b     = n_q;
    mul_a     = rn_q;
    mul_b     = bd_q;
    case (state_q)
      ST_GCD: begin
        if (n_q != '0) begin
          div_start = 1'b1;
        end else if (m_q != '0) begin
          div_start = 1'b1;
          div_a     = num_q;
          div_b     = m_q;
        end
      end
      ST_RNUM: begin
        div_start = div_stat.done;
        div_a     = den_q;
        div_b     = m_q;
      end
      ST_MSN1: begin
        mul_a = rd_q;
        mul_b = bn_q;
      end
      ST_MSD, ST_MPD: begin
        mul_a = rd_q;
        mul_b = bd_q;
      end
      ST_MPN: begin
        mul_a = rn_q;
        mul_b = bn_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) phase_q <= PH_FIRST;
      else if (state_q == ST_MSD) phase_q <= PH_SUM;
      else if (state_q == ST_MPD) phase_q <= PH_PROD;
      if (state_q == ST_OUT && state_d == ST_IDLE) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          num_q <= DW'(first_num_i);
          den_q <= DW'(first_den_i);
          m_q   <= DW'(first_num_i);
          n_q   <= DW'(first_den_i);
          bn_q  <= second_num_i;
          bd_q  <= second_den_i;
        end
      end
      ST_GCD: undef_q <= (n_q == '0) && (m_q == '0);
      ST_GWAIT: begin
        if (div_stat.done) begin
          m_q <= n_q;
          n_q <= div_rem;
        end
      end
      ST_RNUM: if (div_stat.done) num_q <= div_quot;
      ST_RDEN: if (div_stat.done) den_q <= div_quot;
      ST_STORE: begin
        case (phase_q)
          PH_FIRST: begin
            rn_q <= num_q[16:0];
            rd_q <= den_q[16:0];
            ua_q <= undef_q;
          end
          PH_SUM: begin
            sn_q <= num_q[31:0];
            sd_q <= den_q[30:0];
            us_q <= undef_q;
          end
          default: begin
            t_q <= t_q;
          end
        endcase
      end
      ST_OUT: begin
        // load only once the previous transaction has left
        if (!out_valid_q || !out_stall_i) begin
          reduced_num_o      <= rn_q[15:0];
          reduced_den_o      <= rd_q[15:0];
          sum_num_o          <= sn_q;
          sum_den_o          <= sd_q;
          prod_num_o         <= num_q[30:0];
          prod_den_o         <= den_q[30:0];
          reduce_undefined_o <= ua_q;
          sum_undefined_o    <= us_q;
          prod_undefined_o   <= undef_q;
        end
      end
      ST_MSN0: t_q <= mul_x;
      ST_MSN1: num_q <= t_q + mul_x;
      ST_MSD, ST_MPD: begin
        den_q <= mul_x;
        m_q   <= num_q;
        n_q   <= mul_x;
      end
      ST_MPN: num_q <= mul_x;
      default: begin
        t_q <= t_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `RAMR_ASSERT(a_start_idle_div, clk_i, rst_ni, div_start |-> !div_stat.busy)
  `RAMR_ASSERT(a_done_in_work, clk_i, rst_ni, div_stat.done |-> (state_q != ST_IDLE))
  `RAMR_ASSERT_NEXT(a_valid_from_out, clk_i, rst_ni, !out_valid_q && (state_q != ST_OUT), !out_valid_q)
endmodule

### bench/tb_top.sv
module tb_top;

  typedef struct {
    logic signed [15:0] an;
    logic signed [15:0] ad;
    logic signed [15:0] bn;
    logic signed [15:0] bd;
  } frac_pair_t;

  typedef struct {
    logic signed [15:0] rn;
    logic signed [15:0] rd;
    logic signed [31:0] sn;
    logic signed [30:0] sd;
    logic signed [30:0] pn;
    logic signed [30:0] pd;
    logic               ru;
    logic               su;
    logic               pu;
  } frac_result_t;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] first_num_i = '0, first_den_i = '0;
  logic signed [15:0] second_num_i = '0, second_den_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] reduced_num_o, reduced_den_o;
  logic signed [31:0] sum_num_o;
  logic signed [30:0] sum_den_o, prod_num_o, prod_den_o;
  logic reduce_undefined_o, sum_undefined_o, prod_undefined_o;

  frac_pair_t   pending_q[$];
  frac_result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_gap = 0;
  int out_gap = 0;
  bit drain_req = 0;
  bit stim_done = 0;

  rational_add_mul_reduce u_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint trunc_gcd(longint m, longint n);
    longint t;
    while (n != 0) begin
      t = m % n;
      m = n;
      n = t;
    end
    return m;
  endfunction

  function automatic frac_result_t add_mul_reduce(frac_pair_t p);
    frac_result_t r;
    longint an, ad, bn, bd, sn, sd, pn, pd, g;
    an = p.an; ad = p.ad; bn = p.bn; bd = p.bd;
    g = trunc_gcd(an, ad);
    r.ru = (g == 0);
    if (g != 0) begin
      an = an / g;
      ad = ad / g;
    end
    sn = an * bd + ad * bn;
    sd = ad * bd;
    g = trunc_gcd(sn, sd);
    r.su = (g == 0);
    if (g != 0) begin
      sn = sn / g;
      sd = sd / g;
    end
    pn = an * bn;
    pd = ad * bd;
    g = trunc_gcd(pn, pd);
    r.pu = (g == 0);
    if (g != 0) begin
      pn = pn / g;
      pd = pd / g;
    end
    r.rn = an[15:0]; r.rd = ad[15:0];
    r.sn = sn[31:0]; r.sd = sd[30:0];
    r.pn = pn[30:0]; r.pd = pd[30:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 40) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  function automatic logic signed [15:0] rand_val();
    case ($urandom_range(0, 9))
      0: return 16'(0);
      1: return 16'($urandom_range(0, 1) ? 1 : -1);
      2: return 16'($urandom_range(0, 1) ? 32767 : -32767);
      3: return 16'(-32768);
      4, 5: return 16'(int'($urandom_range(0, 40)) - 20);
      6, 7: return 16'(($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 6 : -12));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_item(int a, int b, int c, int d);
    frac_pair_t p;
    p.an = 16'(a); p.ad = 16'(b); p.bn = 16'(c); p.bd = 16'(d);
    pending_q.push_back(p);
  endtask

  // driver
  always @(posedge clk_i) begin
    frac_pair_t p;
    if (in_valid_i && !in_stall_o) begin
      p.an = first_num_i; p.ad = first_den_i;
      p.bn = second_num_i; p.bd = second_den_i;
      expected_q.push_back(add_mul_reduce(p));
      hold_gap = pick_gap();
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (hold_gap > 0) begin
        hold_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0 && rst_ni &&
                   !(drain_req && expected_q.size() > 0)) begin
        drain_req = 0;
        p = pending_q.pop_front();
        in_valid_i   <= 1'b1;
        first_num_i  <= p.an;
        first_den_i  <= p.ad;
        second_num_i <= p.bn;
        second_den_i <= p.bd;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    frac_result_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $display("unexpected transaction on output");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (reduced_num_o !== e.rn) report("reduced_num", reduced_num_o, e.rn);
        if (reduced_den_o !== e.rd) report("reduced_den", reduced_den_o, e.rd);
        if (sum_num_o !== e.sn) report("sum_num", sum_num_o, e.sn);
        if (sum_den_o !== e.sd) report("sum_den", sum_den_o, e.sd);
        if (prod_num_o !== e.pn) report("prod_num", prod_num_o, e.pn);
        if (prod_den_o !== e.pd) report("prod_den", prod_den_o, e.pd);
        if (reduce_undefined_o !== e.ru) report("reduce_undefined", reduce_undefined_o, e.ru);
        if (sum_undefined_o !== e.su) report("sum_undefined", sum_undefined_o, e.su);
        if (prod_undefined_o !== e.pu) report("prod_undefined", prod_undefined_o, e.pu);
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_gap = pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    push_item(0, 0, 5, 7);
    push_item(0, 0, 0, 0);
    push_item(3, 6, 0, 0);
    push_item(0, 5, 0, 3);
    push_item(32767, 32767, 32767, 32767);
    push_item(-32767, -32767, -32767, -32767);
    push_item(32767, -32767, -32767, 32767);
    push_item(-32768, -1, 1, 1);
    push_item(-32768, -32768, -32768, -32768);
    push_item(-32768, 1, -32768, 1);
    push_item(1, 2, -1, 2);
    push_item(6, -4, 9, 15);
    push_item(-6, 4, -9, -15);
    push_item(5, 0, 3, 0);
    push_item(0, 7, 2, 0);
    push_item(12, 18, 0, 0);
    push_item(1, 3, 1, 6);
    push_item(-1, 1, 32767, -32768);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    for (int k = 0; k < 1650; k++) begin
      push_item(rand_val(), rand_val(), rand_val(), rand_val());
      if (k == 700) begin
        wait (pending_q.size() == 0);
        drain_req = 1;
      end
    end
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ramr_pkg.sv
hw/rtl/ramr_div.sv
hw/rtl/rational_add_mul_reduce.sv
bench/tb_top.sv
